@@ rtl/fib_pkg.sv @@
package fib_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int REQ_W  = 21;
    localparam int OFF_W  = 20;
    localparam int STAT_W = 3;

    // Command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Response status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT    = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTSTART = 3'd3;
    localparam logic [STAT_W-1:0] ST_CORRUPT  = 3'd4;
    localparam logic [STAT_W-1:0] ST_NULL     = 3'd5;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_GRAB,
        S_SPLIT,
        S_AMARK,
        S_FMARK,
        S_MRDC,
        S_MLDC,
        S_MRDN,
        S_MEVN,
        S_DONE
    } state_t;

endpackage

@@ rtl/fib_ram.sv @@
module fib_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/first_fit_block_allocator.sv @@
// First-fit block allocator with coalescing.
// Requests arrive on the s_ stream: s_tuser carries the command (allocate or
// free) and the null-pointer flag, s_tdata carries the requested size and the
// payload offset to free. Each request gives exactly one response on the m_
// stream: m_tuser is the status code and m_tdata the allocated payload offset
// (zero unless an allocate succeeds).
// The block handles one request at a time; s_tready is high only while idle.
// An allocate walks the block chain one slot at a time (table read, then
// evaluate), and when a block is split it scans the slot map for a free slot.
// A free walks to its block the same way and then makes a merge pass along
// the chain links. The block table memory, with its one read port and
// registered read, sets the pace of these walks.
// The response sits in an output register. While m_tready is stalled the block
// still takes the next request and works on it, then holds in its final state
// until the output register is free again.
// After reset the arena is a single free block and no clearing pass is needed.
module first_fit_block_allocator #(
    parameter int ARENA_BYTES  = 1048576,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [20:0] req_size, [40:21] ptr_offset, rest zero
    input  logic [1:0]  s_tuser,   // [0] cmd, [1] ptr_null
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [19:0] payload_offset, rest zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    localparam int AW  = $clog2(ARENA_BYTES + 1);
    localparam int SLW = $clog2(MAX_BLOCKS);
    localparam int NW  = $clog2(MAX_BLOCKS + 1);
    localparam int CW  = (AW > fib_pkg::REQ_W) ? AW + 2 : fib_pkg::REQ_W + 2;
    localparam int EW  = 2 * AW + 1 + NW;

    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
    localparam logic [NW-1:0] NO_SLOT = NW'(MAX_BLOCKS);
    localparam logic [AW-1:0] RST_SZ  = AW'(ARENA_BYTES - HEADER_BYTES);

    fib_pkg::state_t state_reg, state_next;

    logic [MAX_BLOCKS-1:0]      inuse_reg, inuse_next;
    logic                       slot0_wr_reg;
    logic                       rd_zero_reg;
    logic [SLW-1:0]             cur_reg, cur_next;
    logic [SLW-1:0]             nidx_reg, nidx_next;
    logic [NW-1:0]              steps_reg, steps_next;
    logic [NW-1:0]              gidx_reg, gidx_next;
    logic                       split_reg, split_next;
    logic                       cmd_reg, cmd_next;
    logic [fib_pkg::REQ_W-1:0]  req_reg, req_next;
    logic [fib_pkg::OFF_W-1:0]  ptr_reg, ptr_next;
    logic [AW-1:0]              cs_reg, cs_next;
    logic [AW-1:0]              csz_reg, csz_next;
    logic                       cf_reg, cf_next;
    logic [NW-1:0]              cn_reg, cn_next;
    logic [fib_pkg::STAT_W-1:0] st_reg, st_next;
    logic [fib_pkg::OFF_W-1:0]  off_reg, off_next;
    logic                       mv_reg, mv_next;
    logic [fib_pkg::STAT_W-1:0] mst_reg, mst_next;
    logic [fib_pkg::OFF_W-1:0]  moff_reg, moff_next;

    logic           ram_we;
    logic [SLW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0]  ram_wdata, ram_rdata;

    logic [AW-1:0] rd_start, rd_size;
    logic          rd_free;
    logic [NW-1:0] rd_next;

    // Follow a link: a missing or retired successor ends the chain.
    function automatic logic [NW-1:0] link_of(input logic [NW-1:0] nv,
                                               input logic [MAX_BLOCKS-1:0] map);
        logic [NW-1:0] res;
        res = NO_SLOT;
        if (nv < NO_SLOT)
        begin
            if (map[nv[SLW-1:0]])
            begin
                res = nv;
            end
        end
        return res;
    endfunction

    fib_ram #(
        .WIDTH(EW),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Slot 0 reads as the whole free arena until it is first written.
    always_comb
    begin
        if (rd_zero_reg && !slot0_wr_reg)
        begin
            rd_start = '0;
            rd_size  = RST_SZ;
            rd_free  = 1'b1;
            rd_next  = NO_SLOT;
        end
        else
        begin
            rd_start = ram_rdata[AW-1:0];
            rd_size  = ram_rdata[2*AW-1:AW];
            rd_free  = ram_rdata[2*AW];
            rd_next  = ram_rdata[EW-1:2*AW+1];
        end
    end

    // Sequencer: next state, table accesses and response.
    always_comb
    begin
        logic [NW-1:0] lnk;
        logic [NW-1:0] stp;
        logic [CW-1:0] blk_end;

        state_next = state_reg;
        inuse_next = inuse_reg;
        cur_next   = cur_reg;
        nidx_next  = nidx_reg;
        steps_next = steps_reg;
        gidx_next  = gidx_reg;
        split_next = split_reg;
        cmd_next   = cmd_reg;
        req_next   = req_reg;
        ptr_next   = ptr_reg;
        cs_next    = cs_reg;
        csz_next   = csz_reg;
        cf_next    = cf_reg;
        cn_next    = cn_reg;
        st_next    = st_reg;
        off_next   = off_reg;
        mv_next    = mv_reg;
        mst_next   = mst_reg;
        moff_next  = moff_reg;
        ram_we     = 1'b0;
        ram_waddr  = cur_reg;
        ram_wdata  = '0;
        ram_raddr  = cur_reg;
        lnk        = link_of(rd_next, inuse_reg);
        stp        = steps_reg + NW'(1);
        blk_end    = CW'(cs_reg) + HDR_C + CW'(csz_reg);

        if (mv_reg && m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            fib_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next   = s_tuser[0];
                    req_next   = s_tdata[20:0];
                    ptr_next   = s_tdata[40:21];
                    off_next   = '0;
                    cur_next   = '0;
                    steps_next = '0;
                    state_next = fib_pkg::S_RD;
                    if (s_tuser[0] == fib_pkg::CMD_ALLOC)
                    begin
                        if (s_tdata[20:0] == '0)
                        begin
                            st_next    = fib_pkg::ST_NOFIT;
                            state_next = fib_pkg::S_DONE;
                        end
                    end
                    else if (s_tuser[1])
                    begin
                        st_next    = fib_pkg::ST_NULL;
                        state_next = fib_pkg::S_DONE;
                    end
                    else if (CW'(s_tdata[40:21]) < HDR_C || CW'(s_tdata[40:21]) >= ARENA_C)
                    begin
                        st_next    = fib_pkg::ST_RANGE;
                        state_next = fib_pkg::S_DONE;
                    end
                end
            end

            fib_pkg::S_RD:
            begin
                state_next = fib_pkg::S_EVAL;
            end

            fib_pkg::S_EVAL:
            begin
                cs_next    = rd_start;
                csz_next   = rd_size;
                cf_next    = rd_free;
                cn_next    = rd_next;
                split_next = 1'b0;
                if (cmd_reg == fib_pkg::CMD_ALLOC && rd_free
                    && CW'(rd_size) >= CW'(req_reg))
                begin
                    if (CW'(rd_size) >= CW'(req_reg) + HDR_C + CW'(1))
                    begin
                        gidx_next  = NW'(1);
                        state_next = fib_pkg::S_GRAB;
                    end
                    else
                    begin
                        state_next = fib_pkg::S_AMARK;
                    end
                end
                else if (cmd_reg == fib_pkg::CMD_FREE
                         && CW'(rd_start) + HDR_C == CW'(ptr_reg))
                begin
                    state_next = fib_pkg::S_FMARK;
                end
                else
                begin
                    steps_next = stp;
                    if (lnk == NO_SLOT || stp == NO_SLOT)
                    begin
                        st_next    = (cmd_reg == fib_pkg::CMD_ALLOC) ?
                                     fib_pkg::ST_NOFIT : fib_pkg::ST_NOTSTART;
                        state_next = fib_pkg::S_DONE;
                    end
                    else
                    begin
                        cur_next   = lnk[SLW-1:0];
                        state_next = fib_pkg::S_RD;
                    end
                end
            end

            // Scan the slot map one slot a cycle for the lowest free slot.
            fib_pkg::S_GRAB:
            begin
                if (gidx_reg == NO_SLOT)
                begin
                    state_next = fib_pkg::S_AMARK;
                end
                else if (!inuse_reg[gidx_reg[SLW-1:0]])
                begin
                    split_next = 1'b1;
                    state_next = fib_pkg::S_SPLIT;
                end
                else
                begin
                    gidx_next = gidx_reg + NW'(1);
                end
            end

            // Write the remainder block into the new slot.
            fib_pkg::S_SPLIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = gidx_reg[SLW-1:0];
                ram_wdata = {link_of(cn_reg, inuse_reg), 1'b1,
                             AW'(CW'(csz_reg) - CW'(req_reg) - HDR_C),
                             AW'(CW'(cs_reg) + HDR_C + CW'(req_reg))};
                inuse_next[gidx_reg[SLW-1:0]] = 1'b1;
                state_next = fib_pkg::S_AMARK;
            end

            fib_pkg::S_AMARK:
            begin
                ram_we     = 1'b1;
                ram_wdata  = {split_reg ? gidx_reg : cn_reg, 1'b0,
                              split_reg ? AW'(req_reg) : csz_reg, cs_reg};
                st_next    = fib_pkg::ST_OK;
                off_next   = fib_pkg::OFF_W'(CW'(cs_reg) + HDR_C);
                state_next = fib_pkg::S_DONE;
            end

            fib_pkg::S_FMARK:
            begin
                ram_we     = 1'b1;
                ram_wdata  = {cn_reg, 1'b1, csz_reg, cs_reg};
                cur_next   = '0;
                steps_next = '0;
                state_next = fib_pkg::S_MRDC;
            end

            fib_pkg::S_MRDC:
            begin
                state_next = fib_pkg::S_MLDC;
            end

            fib_pkg::S_MLDC:
            begin
                cs_next    = rd_start;
                csz_next   = rd_size;
                cf_next    = rd_free;
                cn_next    = rd_next;
                state_next = fib_pkg::S_MRDN;
            end

            // Fetch the successor of the current block.
            fib_pkg::S_MRDN:
            begin
                lnk = link_of(cn_reg, inuse_reg);
                if (steps_reg == NO_SLOT || lnk == NO_SLOT)
                begin
                    st_next    = fib_pkg::ST_OK;
                    state_next = fib_pkg::S_DONE;
                end
                else
                begin
                    ram_raddr  = lnk[SLW-1:0];
                    nidx_next  = lnk[SLW-1:0];
                    state_next = fib_pkg::S_MEVN;
                end
            end

            // Check contiguity, then merge or step forward.
            fib_pkg::S_MEVN:
            begin
                ram_raddr = nidx_reg;
                if (CW'(rd_start) != blk_end)
                begin
                    st_next    = fib_pkg::ST_CORRUPT;
                    state_next = fib_pkg::S_DONE;
                end
                else
                begin
                    steps_next = stp;
                    state_next = fib_pkg::S_MRDN;
                    if (cf_reg && rd_free)
                    begin
                        csz_next  = AW'(CW'(csz_reg) + HDR_C + CW'(rd_size));
                        cn_next   = lnk;
                        inuse_next[nidx_reg] = 1'b0;
                        ram_we    = 1'b1;
                        ram_wdata = {lnk, cf_reg,
                                     AW'(CW'(csz_reg) + HDR_C + CW'(rd_size)), cs_reg};
                    end
                    else
                    begin
                        cur_next = nidx_reg;
                        cs_next  = rd_start;
                        csz_next = rd_size;
                        cf_next  = rd_free;
                        cn_next  = rd_next;
                    end
                end
            end

            fib_pkg::S_DONE:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next    = 1'b1;
                    mst_next   = st_reg;
                    moff_next  = off_reg;
                    state_next = fib_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = fib_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= fib_pkg::S_IDLE;
            inuse_reg    <= MAX_BLOCKS'(1);
            slot0_wr_reg <= 1'b0;
            mv_reg       <= 1'b0;
            steps_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            inuse_reg <= inuse_next;
            mv_reg    <= mv_next;
            steps_reg <= steps_next;
            if (ram_we && ram_waddr == '0)
            begin
                slot0_wr_reg <= 1'b1;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        rd_zero_reg <= (ram_raddr == '0);
        cur_reg     <= cur_next;
        nidx_reg    <= nidx_next;
        gidx_reg    <= gidx_next;
        split_reg   <= split_next;
        cmd_reg     <= cmd_next;
        req_reg     <= req_next;
        ptr_reg     <= ptr_next;
        cs_reg      <= cs_next;
        csz_reg     <= csz_next;
        cf_reg      <= cf_next;
        cn_reg      <= cn_next;
        st_reg      <= st_next;
        off_reg     <= off_next;
        mst_reg     <= mst_next;
        moff_reg    <= moff_next;
    end

    assign s_tready = (state_reg == fib_pkg::S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tuser  = mst_reg;
    assign m_tdata  = {4'b0, moff_reg};

    // The head block is never retired.
    a_head_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        inuse_reg[0])
        else $error("slot 0 left the chain");

    // Table writes happen only in the write steps of the sequencer.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == fib_pkg::S_SPLIT || state_reg == fib_pkg::S_AMARK
                    || state_reg == fib_pkg::S_FMARK || state_reg == fib_pkg::S_MEVN))
        else $error("table write outside a write step");

    // A split only takes a slot that the scan found free.
    a_split_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fib_pkg::S_SPLIT) |-> (gidx_reg < NO_SLOT
                                             && !inuse_reg[gidx_reg[SLW-1:0]]))
        else $error("split into a slot in use");

    // Walks stay within the step bound.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= NO_SLOT)
        else $error("walk ran past the step bound");

    // A failed response never carries an offset.
    a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fib_pkg::S_DONE && st_reg != fib_pkg::ST_OK) |-> (off_reg == '0))
        else $error("offset on a failed response");

endmodule

@@ tb/tb_top.sv @@
module tb_top;

    localparam int ARENA  = 1048576;
    localparam int HDR    = 24;
    localparam int NSLOT  = 64;
    localparam int NONE   = NSLOT;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        cmd;
        logic        is_null;
        logic [20:0] size;
        logic [19:0] ptr;
    } alloc_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] offset;
    } alloc_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // [20:0] req_size, [40:21] ptr_offset, rest zero
    logic [1:0]  s_tuser;   // [0] cmd, [1] ptr_null
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [19:0] payload_offset, rest zero
    logic [2:0]  m_tuser;   // [2:0] status

    // Shadow copy of the block table used to predict responses.
    int unsigned blk_start [NSLOT];
    int unsigned blk_size  [NSLOT];
    bit          blk_free  [NSLOT];
    int unsigned blk_next  [NSLOT];
    bit          slot_used [NSLOT];

    alloc_req_t  pending_reqs[$];
    alloc_rsp_t  expected_rsps[$];
    int unsigned live_offsets[$];
    int          mismatches;
    int          idle_cycles;
    bit          stim_done;
    bit          calm;
    bit          hold_off;
    bit          in_acc;
    int          send_gap;
    int          recv_gap;
    int          hold_cnt;

    first_fit_block_allocator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned next_of(int unsigned s);
        int unsigned n;
        if (s >= NONE)
            return NONE;
        n = blk_next[s];
        if (n >= NONE || !slot_used[n])
            return NONE;
        return n;
    endfunction

    function automatic void table_reset();
        for (int i = 0; i < NSLOT; i++)
        begin
            blk_start[i] = 0;
            blk_size[i]  = 0;
            blk_free[i]  = 0;
            blk_next[i]  = NONE;
            slot_used[i] = 0;
        end
        blk_size[0]  = ARENA - HDR;
        blk_free[0]  = 1;
        slot_used[0] = 1;
    endfunction

    // First-fit search with split; returns the status and the payload offset.
    function automatic logic [2:0] allocate_block(int unsigned size, output int unsigned off);
        int unsigned cur;
        int unsigned r;
        cur = 0;
        off = 0;
        if (size == 0)
            return fib_pkg::ST_NOFIT;
        for (int steps = 0; cur < NONE && steps < NSLOT; steps++)
        begin
            if (blk_free[cur] && blk_size[cur] >= size)
            begin
                if (blk_size[cur] >= size + HDR + 1)
                begin
                    r = NONE;
                    for (int i = NSLOT - 1; i >= 1; i--)
                        if (!slot_used[i])
                            r = i;
                    if (r < NONE)
                    begin
                        slot_used[r] = 1;
                        blk_start[r] = blk_start[cur] + HDR + size;
                        blk_size[r]  = blk_size[cur] - size - HDR;
                        blk_free[r]  = 1;
                        blk_next[r]  = next_of(cur);
                        blk_size[cur] = size;
                        blk_next[cur] = r;
                    end
                end
                blk_free[cur] = 0;
                off = (blk_start[cur] + HDR) & 20'hFFFFF;
                return fib_pkg::ST_OK;
            end
            cur = next_of(cur);
        end
        return fib_pkg::ST_NOFIT;
    endfunction

    // Marks a block free and then coalesces neighboring free blocks in one pass.
    function automatic logic [2:0] release_block(int unsigned ptr);
        int unsigned cur;
        int unsigned n;
        int steps;
        if (ptr < HDR || ptr >= ARENA)
            return fib_pkg::ST_RANGE;
        cur = 0;
        for (steps = 0; cur < NONE && steps < NSLOT; steps++)
        begin
            if (blk_start[cur] + HDR == ptr)
                break;
            cur = next_of(cur);
        end
        if (cur >= NONE || steps >= NSLOT)
            return fib_pkg::ST_NOTSTART;
        blk_free[cur] = 1;
        cur = 0;
        for (steps = 0; steps < NSLOT; steps++)
        begin
            n = next_of(cur);
            if (n >= NONE)
                break;
            if (blk_start[n] != blk_start[cur] + HDR + blk_size[cur])
                return fib_pkg::ST_CORRUPT;
            if (blk_free[cur] && blk_free[n])
            begin
                blk_size[cur] += HDR + blk_size[n];
                blk_next[cur] = next_of(n);
                slot_used[n] = 0;
                blk_start[n] = 0;
                blk_size[n]  = 0;
                blk_free[n]  = 0;
                blk_next[n]  = NONE;
            end
            else
                cur = n;
        end
        return fib_pkg::ST_OK;
    endfunction

    function automatic alloc_rsp_t predict_response(alloc_req_t req);
        alloc_rsp_t rsp;
        int unsigned off;
        off = 0;
        if (req.cmd == fib_pkg::CMD_ALLOC)
            rsp.status = allocate_block(req.size, off);
        else if (req.is_null)
            rsp.status = fib_pkg::ST_NULL;
        else
            rsp.status = release_block(req.ptr);
        rsp.offset = 20'(off);
        return rsp;
    endfunction

    function automatic alloc_req_t make_req(logic cmd, logic is_null, int unsigned size,
                                            int unsigned ptr);
        alloc_req_t req;
        req.cmd     = cmd;
        req.is_null = is_null;
        req.size    = 21'(size);
        req.ptr     = 20'(ptr);
        return req;
    endfunction

    // Mostly small sizes, with an occasional large or extreme one.
    function automatic int unsigned pick_size();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < 70)
            return $urandom_range(1, 4096);
        else if (k < 85)
            return $urandom_range(1, 60000);
        else if (k < 95)
            return $urandom_range(0, 21'h1FFFFF);
        else
            return ARENA - HDR - $urandom_range(0, 2);
    endfunction

    // Directed cases first, then a random mix of allocate and free traffic.
    initial
    begin
        int unsigned r;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
        rst_n    = 1'b0;
        mismatches = 0;
        stim_done  = 0;
        calm       = 0;
        hold_off   = 0;
        table_reset();
        pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b0, 0, 0));
        pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b1, 21'h1FFFFF, 20'hFFFFF));
        pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b0, ARENA, 0));
        pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b0, ARENA - HDR, 0));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, HDR));
        pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b0, ARENA - 2 * HDR, 0));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, HDR));
        pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b0, 1, 0));
        pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b0, 100, 0));
        pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b0, 1, 0));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b1, 21'h1FFFFF, 20'hFFFFF));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, 0));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, HDR - 1));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, 20'hFFFFF));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, HDR + 1));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, 2 * HDR + 1));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, 2 * HDR + 1));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, HDR));
        pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0, 3 * HDR + 101));
        // Exhaust the slot table so a block is handed out whole.
        for (int i = 0; i < 66; i++)
            pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b0,
                                            $urandom_range(1, 64), 0));
        pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'b0, 8, 0));
        // Build a list of offsets that an allocate of the same sequence returns.
        begin
            alloc_rsp_t p;
            foreach (pending_reqs[i])
            begin
                p = predict_response(pending_reqs[i]);
                if (pending_reqs[i].cmd == fib_pkg::CMD_ALLOC && p.status == fib_pkg::ST_OK)
                    live_offsets.push_back(p.offset);
            end
        end
        table_reset();
        for (int i = 0; i < 600; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                pending_reqs.push_back(make_req(fib_pkg::CMD_ALLOC, 1'($urandom_range(0, 1)),
                                                pick_size(), $urandom_range(0, 20'hFFFFF)));
            else if (r < 85 && live_offsets.size() > 0)
            begin
                int k;
                k = $urandom_range(0, live_offsets.size() - 1);
                pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0,
                                                $urandom_range(0, 21'h1FFFFF),
                                                live_offsets[k]));
                live_offsets.delete(k);
            end
            else if (r < 92)
                pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b0, 0,
                                                $urandom_range(0, 20'hFFFFF)));
            else
                pending_reqs.push_back(make_req(fib_pkg::CMD_FREE, 1'b1,
                                                $urandom_range(0, 21'h1FFFFF),
                                                $urandom_range(0, 20'hFFFFF)));
            // An allocate pushes a zero offset here, and a trailing zero is popped again at once.
            if (pending_reqs[$].cmd == fib_pkg::CMD_ALLOC && !pending_reqs[$].is_null
                && pending_reqs[$].size != 0 && pending_reqs[$].size < 60000)
                live_offsets.push_back(0);
            if (live_offsets.size() > 0 && live_offsets[$] == 0)
                live_offsets.delete(live_offsets.size() - 1);
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Offsets handed out by the block feed later free requests.
    int unsigned granted[$];

    // Driver: holds each request until it is accepted, with random gaps between.
    always @(negedge clk)
    begin
        alloc_req_t req;
        if (rst_n)
        begin
            if (!(s_tvalid && !in_acc))
            begin
                if (in_acc)
                    void'(pending_reqs.pop_front());
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    req = pending_reqs[0];
                    // Most random frees are redirected to an offset the block really granted.
                    if (req.cmd == fib_pkg::CMD_FREE && !req.is_null && granted.size() > 0
                        && $urandom_range(0, 9) < 8 && pending_reqs.size() < 600)
                    begin
                        int k;
                        k = $urandom_range(0, granted.size() - 1);
                        req.ptr = 20'(granted[k]);
                        granted.delete(k);
                        pending_reqs[0] = req;
                    end
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, req.ptr, req.size};
                    s_tuser  <= {req.is_null, req.cmd};
                    if (!calm && $urandom_range(0, 15) == 0)
                        send_gap <= $urandom_range(1, 8);
                end
                else
                    s_tvalid <= 1'b0;
            end
            if (pending_reqs.size() < 100)
                calm <= 1;
        end
    end

    // Receiver: random stalls and one long hold-off while requests keep coming.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            recv_gap <= 0;
            hold_cnt <= 0;
        end
        else if (!hold_off && pending_reqs.size() < 500 && pending_reqs.size() > 400)
        begin
            hold_off <= 1;
            hold_cnt <= 400;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 15) == 0)
                recv_gap <= $urandom_range(1, 8);
        end
    end

    // Monitor: predicts on each accepted request and checks each accepted response.
    always @(posedge clk)
    begin
        alloc_req_t req;
        alloc_rsp_t want;
        if (rst_n)
        begin
            in_acc <= s_tvalid && s_tready;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready)
            begin
                req.cmd     = s_tuser[0];
                req.is_null = s_tuser[1];
                req.size    = s_tdata[20:0];
                req.ptr     = s_tdata[40:21];
                expected_rsps.push_back(predict_response(req));
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected response: status %0d offset %0d",
                                 m_tuser, m_tdata[19:0]);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (m_tuser !== want.status || m_tdata !== {4'd0, want.offset})
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected status %0d offset %0d, got %0d %0d",
                                     want.status, want.offset, m_tuser, m_tdata);
                    end
                    else if (want.status == fib_pkg::ST_OK && want.offset != 0)
                        granted.push_back(want.offset);
                end
            end
        end
        else
        begin
            idle_cycles <= 0;
            in_acc      <= 1'b0;
        end
    end

    // End of run and watchdog.
    initial
    begin
        @(posedge rst_n);
        while (!(pending_reqs.size() == 0 && expected_rsps.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
        else
        begin
            repeat (300) @(posedge clk);
            if (mismatches == 0 && expected_rsps.size() == 0)
                $display("tb_top: PASS");
            else
                $display("tb_top: FAIL");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
rtl/fib_pkg.sv
rtl/fib_ram.sv
rtl/first_fit_block_allocator.sv
tb/tb_top.sv
